/* rtl/wrd_pkg.sv */
// Package for the waveform record deframer: sizes, tag codes, result kinds,
// header and queue entry types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wrd_pkg;

  localparam int POINTS    = 1024;
  localparam int BC_W      = $clog2(POINTS * 4 + 1);
  localparam int POINT_W   = 10;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int N_TIMES   = 7;
  localparam int TIME_IDX_W = 3;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int VOLT_W    = 18;

  // Tags as they sit in the little-endian assembly word.
  localparam logic [WORD_W-1:0] TAG_EHDR    = 32'h5244_4845;
  localparam logic [23:0]       TAG_C00_LOW = 24'h30_3043;
  localparam logic [7:0]        CHAN_DIGIT_FIRST = 8'h31;
  localparam logic [7:0]        CHAN_DIGIT_LAST  = 8'h34;

  // Header layout in bytes after the tag.
  localparam int HDR_EVENT_END = 4;
  localparam int HDR_TIMES_END = 18;
  localparam int HDR_LAST      = 20;

  localparam logic [VOLT_W-1:0] VOLT_OFFSET = 18'd65535;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BIN    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0]                 event_number;
    logic [N_TIMES-1:0][HALF_W-1:0]    times;  // year, month, day, hour, min, sec, ms
  } hdr_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         chan;
    logic [POINT_W-1:0] point;
    logic [WORD_W-1:0]  word;   // assembled bytes; samples sit in bits 31:16
    hdr_t               hdr;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/wrd_if.sv */
// Channel interfaces for the deframer: the byte stream in and the record out.
// Depends on wrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface wrd_rec_if;
  import wrd_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         chan;
  logic [POINT_W-1:0] point;
  logic [WORD_W-1:0]  value;
  logic [WORD_W-1:0]  event_number;
  logic [HALF_W-1:0]  year_field;
  logic [HALF_W-1:0]  month_field;
  logic [HALF_W-1:0]  day_field;
  logic [HALF_W-1:0]  hour_field;
  logic [HALF_W-1:0]  minute_field;
  logic [HALF_W-1:0]  second_field;
  logic [HALF_W-1:0]  milli_field;

  modport source (output valid, output kind, output chan, output point, output value,
                  output event_number, output year_field, output month_field,
                  output day_field, output hour_field, output minute_field,
                  output second_field, output milli_field, input ready);
  modport sink   (input valid, input kind, input chan, input point, input value,
                  input event_number, input year_field, input month_field,
                  input day_field, input hour_field, input minute_field,
                  input second_field, input milli_field, output ready);
endinterface

`default_nettype wire

/* rtl/wrd_front.sv */
// Front end: takes stream words, tracks the record phase, captures the header
// and pushes classified results into the queue. Depends on wrd_pkg, wrd_if.
`timescale 1ns / 1ps
`default_nettype none

module wrd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  wrd_byte_if.sink            stream,
  input  wire logic           q_full,
  output logic                q_push,
  output wrd_pkg::entry_t     q_entry
);
  import wrd_pkg::*;

  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_TIME   = 3'd2;
  localparam logic [2:0] PH_TAG    = 3'd3;
  localparam logic [2:0] PH_CHAN   = 3'd4;
  localparam logic [2:0] PH_HALT   = 3'd5;

  logic [2:0]        phase, phase_next;
  logic [BC_W-1:0]   byte_count, byte_count_next;
  logic [WORD_W-1:0] assembly, assembly_next;
  logic [1:0]        current_chan, current_chan_next;
  hdr_t              header, header_next;

  logic              accept;
  logic [BC_W-1:0]   bc_inc;
  logic [BC_W-1:0]   hoff;
  logic [BC_W-1:0]   bin_idx;
  logic [BC_W-1:0]   smp_idx;
  logic [7:0]        digit;

  // Drop everything once halted, so keep ready high there.
  assign stream.ready = (phase == PH_HALT) || !q_full;
  assign accept       = stream.valid && stream.ready;

  assign assembly_next = {stream.data_byte, assembly[WORD_W-1:8]};
  assign bc_inc        = byte_count + BC_W'(1);
  assign hoff          = bc_inc - BC_W'(6);
  assign bin_idx       = (bc_inc >> 2) - BC_W'(1);
  assign smp_idx       = (bc_inc >> 1) - BC_W'(1);
  assign digit         = assembly_next[31:24];

  always_comb begin
    phase_next        = phase;
    byte_count_next   = bc_inc;
    current_chan_next = current_chan;
    header_next       = header;
    q_push            = 1'b0;
    q_entry.kind      = KIND_HEADER;
    q_entry.chan      = 2'd0;
    q_entry.point     = '0;
    q_entry.word      = '0;
    q_entry.hdr       = header;
    case (phase)
      PH_FIRST, PH_TAG: begin
        if (bc_inc == BC_W'(4)) begin
          byte_count_next = '0;
          if (assembly_next == TAG_EHDR) begin
            phase_next = PH_HEADER;
          end else if (phase == PH_TAG && assembly_next[23:0] == TAG_C00_LOW &&
                       digit >= CHAN_DIGIT_FIRST && digit <= CHAN_DIGIT_LAST) begin
            current_chan_next = 2'(digit - CHAN_DIGIT_FIRST);
            phase_next        = PH_CHAN;
          end else begin
            phase_next   = PH_HALT;
            q_push       = accept;
            q_entry.kind = KIND_BAD;
            q_entry.word = assembly_next;
          end
        end
      end
      PH_HEADER: begin
        if (bc_inc == BC_W'(HDR_EVENT_END)) begin
          header_next.event_number = assembly_next;
        end else if (bc_inc > BC_W'(HDR_EVENT_END) && bc_inc <= BC_W'(HDR_TIMES_END) &&
                     !bc_inc[0]) begin
          header_next.times[hoff[TIME_IDX_W:1]] = assembly_next[31:16];
        end else if (bc_inc >= BC_W'(HDR_LAST)) begin
          byte_count_next = '0;
          phase_next      = PH_TIME;
          q_push          = accept;
          q_entry.kind    = KIND_HEADER;
        end
      end
      PH_TIME: begin
        if (bc_inc[1:0] == 2'd0) begin
          q_push        = accept;
          q_entry.kind  = KIND_BIN;
          q_entry.point = POINT_W'(bin_idx);
          q_entry.word  = assembly_next;
          if (bc_inc >= BC_W'(POINTS * 4)) begin
            byte_count_next = '0;
            phase_next      = PH_TAG;
          end
        end
      end
      PH_CHAN: begin
        if (!bc_inc[0]) begin
          q_push        = accept;
          q_entry.kind  = KIND_SAMPLE;
          q_entry.chan  = current_chan;
          q_entry.point = POINT_W'(smp_idx);
          q_entry.word  = assembly_next;
          if (bc_inc >= BC_W'(POINTS * 2)) begin
            byte_count_next = '0;
            phase_next      = PH_TAG;
          end
        end
      end
      PH_HALT: begin
        byte_count_next = byte_count;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      byte_count   <= '0;
      assembly     <= '0;
      current_chan <= '0;
      header       <= '0;
    end else if (accept && phase != PH_HALT) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      assembly     <= assembly_next;
      current_chan <= current_chan_next;
      header       <= header_next;
    end else if (phase != PH_HALT && phase != PH_FIRST && phase != PH_HEADER &&
                 phase != PH_TIME && phase != PH_TAG && phase != PH_CHAN) begin
      phase <= PH_HALT;
    end
  end

endmodule

`default_nettype wire

/* rtl/wrd_queue.sv */
// Short result queue between front and back end, held in flops.
// Depends on wrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wrd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire wrd_pkg::entry_t push_entry,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output wrd_pkg::entry_t      head
);
  import wrd_pkg::*;

  entry_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/wrd_back.sv */
// Back end: pulls queue entries, turns samples into fixed-point voltage and
// holds the record in the output register. Depends on wrd_pkg, wrd_if.
`timescale 1ns / 1ps
`default_nettype none

module wrd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire wrd_pkg::entry_t q_head,
  output logic                 q_pop,
  wrd_rec_if.source            record
);
  import wrd_pkg::*;

  logic               out_valid;
  logic [1:0]         out_kind;
  logic [1:0]         out_chan;
  logic [POINT_W-1:0] out_point;
  logic [WORD_W-1:0]  out_value;
  hdr_t               out_hdr;
  logic [VOLT_W-1:0]  volt;
  logic [WORD_W-1:0]  value_next;

  // 2*raw - 65535, exact in 18 bits signed
  assign volt = {1'b0, q_head.word[31:16], 1'b0} - VOLT_OFFSET;

  always_comb begin
    case (q_head.kind)
      KIND_SAMPLE: value_next = {{(WORD_W - VOLT_W){volt[VOLT_W-1]}}, volt};
      default:     value_next = q_head.word;
    endcase
  end

  assign q_pop = q_valid && (!out_valid || record.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || record.ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_kind  <= q_head.kind;
      out_chan  <= q_head.chan;
      out_point <= q_head.point;
      out_value <= value_next;
      out_hdr   <= q_head.hdr;
    end
  end

  assign record.valid        = out_valid;
  assign record.kind         = out_kind;
  assign record.chan         = out_chan;
  assign record.point        = out_point;
  assign record.value        = out_value;
  assign record.event_number = out_hdr.event_number;
  assign record.year_field   = out_hdr.times[0];
  assign record.month_field  = out_hdr.times[1];
  assign record.day_field    = out_hdr.times[2];
  assign record.hour_field   = out_hdr.times[3];
  assign record.minute_field = out_hdr.times[4];
  assign record.second_field = out_hdr.times[5];
  assign record.milli_field  = out_hdr.times[6];

endmodule

`default_nettype wire

/* rtl/waveform_record_deframer_core.sv */
// Top level of the waveform record deframer: front end, result queue, back end.
// Depends on wrd_pkg, wrd_if, wrd_front, wrd_queue, wrd_back.
//
//   channel  | dir | word                     | handshake
//   ---------+-----+--------------------------+-------------------------
//   stream   | in  | one record byte          | valid/ready, data_byte
//   record   | out | one deframed result      | valid/ready, kind..milli
//
// Cycles: one stream word per clock, sustained while the queue is not full; the front
// end's byte counter and assembly shift register are the only per-word loop.
// Path: a result enters the queue at the edge that takes the word completing it;
// the output register loads it from the queue head once empty or being read.
// Reset: synchronous rst returns the deframer to waiting for the first event
// tag and clears the header fields, queue and output register.
// Stalls: a two-entry queue and the output register decouple the sides; the
// stream stalls only when the queue is full. After a bad tag every word is taken
// and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module waveform_record_deframer_core (
  input  wire logic clk,
  input  wire logic rst,
  wrd_byte_if.sink  stream,
  wrd_rec_if.source record
);
  import wrd_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;
  entry_t q_in;
  entry_t q_head;

  // Classify words and build results.
  wrd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // Buffer results so each side can stall on its own.
  wrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Convert samples and drive the output register.
  wrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .record  (record)
  );

  // A result is pushed only for an accepted word.
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (stream.valid && stream.ready))
    else $error("result pushed without an accepted word");

  // Never push into a full queue: a result would be lost.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("result pushed into full queue");

  // The output register is empty right after reset.
  a_out_idle_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !record.valid)
    else $error("record valid right after reset");

  // Bad tag and header results carry no channel or point.
  a_bad_fields: assert property (@(posedge clk) disable iff (rst)
    (record.valid && (record.kind == KIND_BAD || record.kind == KIND_HEADER)) |->
      (record.chan == 2'd0 && record.point == '0))
    else $error("channel or point set on header or bad tag result");

endmodule

`default_nettype wire

/* bench/wrd_record_checker.sv */
// Record checker for the waveform record deframer: tracks stream words, predicts
// each record word and compares it field by field. Depends on wrd_pkg and wrd_if.
`timescale 1ns / 1ps

module wrd_record_checker
  import wrd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  wrd_byte_if         stream,
  wrd_rec_if          record,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned header_count,
  output int unsigned bin_count,
  output int unsigned sample_count,
  output int unsigned bad_count
);

  typedef enum logic [2:0] {
    PH_FIRST, PH_HEADER, PH_TIME, PH_TAG, PH_CHAN, PH_HALT
  } deframe_phase_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         chan;
    logic [POINT_W-1:0] point;
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  event_number;
    logic [HALF_W-1:0]  year;
    logic [HALF_W-1:0]  month;
    logic [HALF_W-1:0]  day;
    logic [HALF_W-1:0]  hour;
    logic [HALF_W-1:0]  minute;
    logic [HALF_W-1:0]  second;
    logic [HALF_W-1:0]  milli;
  } record_t;

  deframe_phase_e    phase;
  logic [BC_W-1:0]   byte_cnt;
  logic [WORD_W-1:0] assembly;
  logic [1:0]        cur_chan;
  logic [WORD_W-1:0] hdr_event;
  logic [HALF_W-1:0] hdr_times [N_TIMES];
  record_t           expected_records [$];

  function automatic string describe(record_t r);
    return $sformatf({"kind=%0d chan=%0d point=%0d value=%h event=%h ",
                      "date=%h-%h-%h time=%h:%h:%h.%h"},
                     r.kind, r.chan, r.point, r.value, r.event_number,
                     r.year, r.month, r.day, r.hour, r.minute, r.second, r.milli);
  endfunction

  // Stamp the current header onto every record word.
  function automatic record_t make_record(logic [1:0] kind, logic [1:0] chan,
                                          logic [POINT_W-1:0] point,
                                          logic [WORD_W-1:0] value);
    record_t r;
    r.kind         = kind;
    r.chan         = chan;
    r.point        = point;
    r.value        = value;
    r.event_number = hdr_event;
    r.year         = hdr_times[0];
    r.month        = hdr_times[1];
    r.day          = hdr_times[2];
    r.hour         = hdr_times[3];
    r.minute       = hdr_times[4];
    r.second       = hdr_times[5];
    r.milli        = hdr_times[6];
    return r;
  endfunction

  // Advance the deframer by one stream word; queue any record word it causes.
  task automatic take_byte(input logic [7:0] b);
    logic [HALF_W-1:0]        raw;
    logic signed [VOLT_W-1:0] volt;
    if (phase == PH_HALT) return;
    assembly = {b, assembly[WORD_W-1:8]};
    byte_cnt = byte_cnt + 1'b1;
    case (phase)
      PH_FIRST, PH_TAG: begin
        if (byte_cnt == 4) begin
          byte_cnt = '0;
          if (assembly == TAG_EHDR) begin
            phase = PH_HEADER;
          end else if (phase == PH_TAG && assembly[23:0] == TAG_C00_LOW &&
                       assembly[31:24] >= CHAN_DIGIT_FIRST &&
                       assembly[31:24] <= CHAN_DIGIT_LAST) begin
            cur_chan = 2'(assembly[31:24] - CHAN_DIGIT_FIRST);
            phase    = PH_CHAN;
          end else begin
            phase = PH_HALT;
            expected_records.push_back(make_record(KIND_BAD, 2'd0, '0, assembly));
          end
        end
      end
      PH_HEADER: begin
        if (byte_cnt == HDR_EVENT_END) begin
          hdr_event = assembly;
        end else if (byte_cnt > HDR_EVENT_END && byte_cnt <= HDR_TIMES_END &&
                     !byte_cnt[0]) begin
          hdr_times[(byte_cnt - 6) >> 1] = assembly[31:16];
        end else if (byte_cnt >= HDR_LAST) begin
          byte_cnt = '0;
          phase    = PH_TIME;
          expected_records.push_back(make_record(KIND_HEADER, 2'd0, '0, '0));
        end
      end
      PH_TIME: begin
        if (byte_cnt[1:0] == 2'b00) begin
          expected_records.push_back(make_record(KIND_BIN, 2'd0,
                                                 POINT_W'((byte_cnt >> 2) - 1'b1),
                                                 assembly));
          if (byte_cnt >= POINTS * 4) begin
            byte_cnt = '0;
            phase    = PH_TAG;
          end
        end
      end
      PH_CHAN: begin
        if (!byte_cnt[0]) begin
          raw  = assembly[31:16];
          volt = {1'b0, raw, 1'b0} - VOLT_OFFSET;
          expected_records.push_back(make_record(KIND_SAMPLE, cur_chan,
                                                 POINT_W'((byte_cnt >> 1) - 1'b1),
                                                 WORD_W'(volt)));
          if (byte_cnt >= POINTS * 2) begin
            byte_cnt = '0;
            phase    = PH_TAG;
          end
        end
      end
      default: phase = PH_HALT;
    endcase
  endtask

  always @(posedge clk) begin
    record_t got;
    record_t want;
    if (rst) begin
      phase     = PH_FIRST;
      byte_cnt  = '0;
      assembly  = '0;
      cur_chan  = '0;
      hdr_event = '0;
      foreach (hdr_times[i]) hdr_times[i] = '0;
      expected_records.delete();
      fail_count   <= 0;
      header_count <= 0;
      bin_count    <= 0;
      sample_count <= 0;
      bad_count    <= 0;
    end else begin
      // Compare first: a record word can never belong to a stream word taken
      // at the same edge.
      if (record.valid && record.ready) begin
        got.kind         = record.kind;
        got.chan         = record.chan;
        got.point        = record.point;
        got.value        = record.value;
        got.event_number = record.event_number;
        got.year         = record.year_field;
        got.month        = record.month_field;
        got.day          = record.day_field;
        got.hour         = record.hour_field;
        got.minute       = record.minute_field;
        got.second       = record.second_field;
        got.milli        = record.milli_field;
        case (got.kind)
          KIND_HEADER: header_count <= header_count + 1;
          KIND_BIN:    bin_count    <= bin_count + 1;
          KIND_SAMPLE: sample_count <= sample_count + 1;
          default:     bad_count    <= bad_count + 1;
        endcase
        if (expected_records.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected record word: %s", $time, describe(got));
          fail_count <= fail_count + 1;
        end else begin
          want = expected_records.pop_front();
          if (got.kind !== want.kind || got.chan !== want.chan ||
              got.point !== want.point || got.value !== want.value ||
              got.event_number !== want.event_number ||
              got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second ||
              got.milli !== want.milli) begin
            if (fail_count < 10)
              $display("%0t: record word differs\n  expected %s\n  actual   %s",
                       $time, describe(want), describe(got));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (stream.valid && stream.ready) take_byte(stream.data_byte);
    end
    pending <= expected_records.size();
  end

endmodule

/* bench/tb_top.sv */
// Top of the deframer testbench: clock, reset, byte stream stimulus, record-side
// stalls and the verdict. Depends on wrd_pkg, wrd_if, the core and wrd_record_checker.
`timescale 1ns / 1ps

module tb_top;
  import wrd_pkg::*;

  // Timeout, far above the slowest legal run (every word and every record word
  // waiting out the longest gap).
  localparam int unsigned LIMIT = 10_000_000;
  // Cycles to wait after the last expected record word; covers the queue and
  // output register.
  localparam int unsigned DRAIN = 16;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZERO} hdr_fill_e;

  logic clk;
  logic rst;

  wrd_byte_if stream_if ();
  wrd_rec_if  record_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned header_count;
  int unsigned bin_count;
  int unsigned sample_count;
  int unsigned bad_count;
  int unsigned cycles;

  // Whole byte stream, planned up front and then fed word by word.
  logic [7:0] stream_bytes [$];

  waveform_record_deframer_core dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .record (record_if)
  );

  wrd_record_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .stream       (stream_if),
    .record       (record_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .header_count (header_count),
    .bin_count    (bin_count),
    .sample_count (sample_count),
    .bad_count    (bad_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r < 20) return 0;
    if (r < 30) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // 16-bit sample or header field: lean on the extremes and the mid-scale pair.
  function automatic logic [HALF_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return HALF_W'($urandom());
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_bin();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Stream is little-endian: low byte goes first.
  task automatic push_word(input logic [WORD_W-1:0] w);
    for (int i = 0; i < 4; i++) stream_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic push_half(input logic [HALF_W-1:0] h);
    stream_bytes.push_back(h[7:0]);
    stream_bytes.push_back(h[15:8]);
  endtask

  // One event: header tag, event number, seven time fields and the reserved
  // half, a full set of time bins, then n_chan channel records, each with a
  // random channel digit.
  task automatic add_event(input hdr_fill_e fill, input int unsigned n_chan);
    logic [7:0]  digit;
    push_word(TAG_EHDR);
    case (fill)
      FILL_ONES: push_word('1);
      FILL_ZERO: push_word('0);
      default:   push_word($urandom());
    endcase
    for (int i = 0; i < N_TIMES + 1; i++) begin
      case (fill)
        FILL_ONES: push_half('1);
        FILL_ZERO: push_half('0);
        default:   push_half(pick_raw());
      endcase
    end
    for (int i = 0; i < POINTS; i++) push_word(pick_bin());
    for (int c = 0; c < n_chan; c++) begin
      digit = 8'($urandom_range(CHAN_DIGIT_FIRST, CHAN_DIGIT_LAST));
      push_word({digit, TAG_C00_LOW});
      for (int i = 0; i < POINTS; i++) push_half(pick_raw());
    end
  endtask

  // Record side: stall at random, with stretches of steady ready.
  initial begin
    int unsigned hold;
    bit          steady;
    record_if.ready = 1'b0;
    hold   = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 499) == 0) steady = !steady;
      if (rst) begin
        record_if.ready <= 1'b0;
      end else if (hold != 0) begin
        record_if.ready <= 1'b0;
        hold--;
      end else begin
        record_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  // Stream side: plan, reset, feed every word, drain, verdict.
  initial begin
    int unsigned      gap;
    bit               steady;
    logic [WORD_W-1:0] bad_tag;
    stream_if.valid     = 1'b0;
    stream_if.data_byte = 8'h00;
    rst    = 1'b1;
    steady = 1'b0;

    // A single event keeps the stream short: random header fields, the full
    // set of time bins and one channel record.
    add_event(FILL_RANDOM, 1);

    // A bad tag halts the block until reset, so it can only close the run.
    // Pick a channel digit just outside the range or an arbitrary word.
    case ($urandom_range(0, 2))
      0:       bad_tag = {CHAN_DIGIT_LAST + 8'd1, TAG_C00_LOW};
      1:       bad_tag = {CHAN_DIGIT_FIRST - 8'd1, TAG_C00_LOW};
      default: bad_tag = $urandom();
    endcase
    push_word(bad_tag);
    // Trailing words the halted block must swallow without a record word.
    repeat (32) stream_bytes.push_back(8'($urandom()));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (stream_bytes[k]) begin
      if ($urandom_range(0, 299) == 0) steady = !steady;
      gap = steady ? 0 : pick_gap();
      // Drop valid only across a gap; back-to-back words keep it high.
      if (gap != 0) begin
        stream_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      stream_if.valid     <= 1'b1;
      stream_if.data_byte <= stream_bytes[k];
      do @(posedge clk); while (!stream_if.ready);
    end
    stream_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Run fed %0d stream words over %0d cycles with random stalls on both sides.",
             stream_bytes.size(), cycles);
    $display("Checked %0d headers, %0d time bins, %0d voltage samples, %0d bad-tag halts.",
             header_count, bin_count, sample_count, bad_count);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: count cycles and end the run if it hangs.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/wrd_pkg.sv
rtl/wrd_if.sv
rtl/wrd_front.sv
rtl/wrd_queue.sv
rtl/wrd_back.sv
rtl/waveform_record_deframer_core.sv
bench/wrd_record_checker.sv
bench/tb_top.sv
